// ===== hdl/bca_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bca_pkg
// Types and constants shared by the binned coverage accumulator modules.
// ----------------------------------------------------------------------------
package bca_pkg;

  localparam int CMD_W     = 2;
  localparam int CONTIG_W  = 8;
  localparam int POS_W     = 31;
  localparam int SPAN_W    = 20;
  localparam int BIDX_W    = 12;
  localparam int SUM_W     = 40;
  localparam int STEP_W    = 16;
  localparam int DIV_W     = 32;
  localparam int DIV_CNT_W = 5;

  localparam logic [STEP_W-1:0] STEP_RESET = 16'd10000;

  localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_DROP  = 2'd1,
    ST_READ  = 2'd2,
    ST_CLAMP = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_DIV_LEFT,
    S_DIV_RIGHT,
    S_CHECK,
    S_BUMP_RD,
    S_BUMP_WR,
    S_DIV_LOAD,
    S_READ_DATA,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [CONTIG_W-1:0] contig;
    logic [POS_W-1:0]    start_pos;
    logic [SPAN_W-1:0]   span_len;
    logic [POS_W-1:0]    contig_length;
    logic [BIDX_W-1:0]   bin_index;
  } in_req_t;

  typedef struct packed {
    status_t            status;
    logic [SUM_W-1:0]   depth_sum;
  } out_rsp_t;

  typedef struct packed {
    logic               start;
    logic [DIV_W-1:0]   dividend;
    logic [STEP_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_W-1:0]   quotient;
    logic [STEP_W-1:0]  remainder;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== hdl/bca_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bca_divider
// Restoring divider, one quotient bit per cycle, shared by the add and load commands.
// ----------------------------------------------------------------------------
module bca_divider (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  bca_pkg::div_req_t  div_req,
  output bca_pkg::div_rsp_t  div_rsp
);

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [bca_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [bca_pkg::DIV_W-1:0]       quo_r, quo_nxt;
  logic [bca_pkg::STEP_W-1:0]      rem_r, rem_nxt;
  logic [bca_pkg::STEP_W-1:0]      dvs_r, dvs_nxt;
  logic [bca_pkg::STEP_W:0]        trial_c;
  logic [bca_pkg::STEP_W:0]        diff_c;
  logic                            ge_c;

  assign trial_c = {rem_r, quo_r[bca_pkg::DIV_W-1]};
  assign diff_c  = trial_c - {1'b0, dvs_r};
  assign ge_c    = trial_c >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (div_req.start) begin
      quo_nxt  = div_req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = div_req.divisor;
      cnt_nxt  = bca_pkg::DIV_CNT_W'(bca_pkg::DIV_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[bca_pkg::DIV_W-2:0], ge_c};
      rem_nxt = ge_c ? diff_c[bca_pkg::STEP_W-1:0] : trial_c[bca_pkg::STEP_W-1:0];
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign div_rsp.done      = done_r;
  assign div_rsp.quotient  = quo_r;
  assign div_rsp.remainder = rem_r;

endmodule
`default_nettype wire

// ===== hdl/bca_depth_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bca_depth_mem
// Single-port bin store with registered read data.
// ----------------------------------------------------------------------------
module bca_depth_mem #(
  parameter int DEPTH = 131072,
  parameter int AW    = 17
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic                        rd_en,
  input  wire logic [AW-1:0]               addr,
  input  wire logic [bca_pkg::SUM_W-1:0]   wr_data,
  output logic      [bca_pkg::SUM_W-1:0]   rd_data
);

  logic [bca_pkg::SUM_W-1:0] mem [DEPTH];
  logic [bca_pkg::SUM_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== hdl/binned_coverage_accumulator_core.sv =====
`default_nettype none
// Throughput: one request at a time; adds and loads share one divider, and every bin
// update is a read-modify-write on the single-port bin store.
// Reset: synchronous, active low; bin_step returns to 10000, all contig bin counts to zero,
// and a clearing pass over all NUM_CONTIGS * BINS_PER_CONTIG entries (131072 by default)
// zeroes the bin store before the first request is taken.
// ----------------------------------------------------------------------------
// binned_coverage_accumulator_core
// Per-contig coverage histogram: intervals are spread over fixed-width bins by
// a shared divider and a read-modify-write sequencer over one bin store.
// ----------------------------------------------------------------------------
module binned_coverage_accumulator_core #(
  parameter int NUM_CONTIGS     = 32,
  parameter int BINS_PER_CONTIG = 4096
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // Request channel.
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  bca_pkg::in_req_t                  in_req,
  // Result channel.
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output bca_pkg::out_rsp_t                 out_rsp,
  // Configuration port for the bin step.
  input  wire logic                         cfg_wr_en,
  input  wire logic [bca_pkg::STEP_W-1:0]   cfg_wr_data
);

  // Every bin of every contig lives in one flat store, contig-major.
  localparam int DEPTH = NUM_CONTIGS * BINS_PER_CONTIG;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CIW   = (NUM_CONTIGS > 1) ? $clog2(NUM_CONTIGS) : 1;
  localparam int BCW   = $clog2(BINS_PER_CONTIG + 1);
  localparam int BIW   = $clog2(BINS_PER_CONTIG);

  bca_pkg::state_t                 state_r, state_nxt;
  bca_pkg::in_req_t                req_r, req_nxt;
  logic                            in_range_r, in_range_nxt;
  logic [AW-1:0]                   base_r, base_nxt;
  logic [bca_pkg::DIV_W-1:0]       left_r, left_nxt;
  logic [bca_pkg::DIV_W-1:0]       right_r, right_nxt;
  logic [bca_pkg::STEP_W-1:0]      rs_r, rs_nxt;
  logic [bca_pkg::STEP_W-1:0]      re_r, re_nxt;
  logic [BIW-1:0]                  cur_bin_r, cur_bin_nxt;
  logic [BIW-1:0]                  last_bin_r, last_bin_nxt;
  logic                            single_r, single_nxt;
  logic                            first_r, first_nxt;
  bca_pkg::status_t                res_status_r, res_status_nxt;
  logic [bca_pkg::SUM_W-1:0]       res_sum_r, res_sum_nxt;
  logic [AW-1:0]                   clr_addr_r, clr_addr_nxt;
  logic                            out_valid_r, out_valid_nxt;
  bca_pkg::out_rsp_t               out_rsp_r, out_rsp_nxt;
  logic [bca_pkg::STEP_W-1:0]      bin_step_r;

  // Contig bin-count table: entries without a valid bit read as zero bins.
  logic [BCW-1:0]                  cb_mem [NUM_CONTIGS];
  logic [NUM_CONTIGS-1:0]          cb_vld_r;
  logic [BCW-1:0]                  cb_bins_r;
  logic                            cb_we_c;
  logic [BCW-1:0]                  cb_wdata_c;
  logic [CIW-1:0]                  cb_widx_c;
  logic [CIW-1:0]                  cb_ridx_c;

  logic                            acc_c;
  logic                            mem_rd_en_c;
  logic                            mem_wr_en_c;
  logic [AW-1:0]                   mem_addr_c;
  logic [bca_pkg::SUM_W-1:0]       mem_wdata_c;
  logic [bca_pkg::SUM_W-1:0]       mem_rd_data;
  logic [bca_pkg::SPAN_W-1:0]      amt_c;
  logic [bca_pkg::DIV_W-1:0]       end_pos_c;
  bca_pkg::div_req_t               div_req_c;
  bca_pkg::div_rsp_t               div_rsp;

  assign acc_c     = in_valid && (state_r == bca_pkg::S_IDLE);
  assign in_stall  = (state_r != bca_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  assign cb_ridx_c = in_req.contig[CIW-1:0];
  assign cb_widx_c = req_r.contig[CIW-1:0];

  // The end of the interval is one past its last covered position.
  assign end_pos_c = {1'b0, req_r.start_pos} + bca_pkg::DIV_W'(req_r.span_len);

  // Amount added to the current bin: the whole span when the interval sits in
  // one bin, the covered tail of the left edge bin, the covered head of the
  // right edge bin, and the full step for every bin in between.
  always_comb begin
    if (single_r) begin
      amt_c = req_r.span_len;
    end else if (first_r) begin
      amt_c = bca_pkg::SPAN_W'(bin_step_r - rs_r);
    end else if (cur_bin_r == last_bin_r) begin
      amt_c = bca_pkg::SPAN_W'(re_r);
    end else begin
      amt_c = bca_pkg::SPAN_W'(bin_step_r);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    in_range_nxt   = in_range_r;
    base_nxt       = base_r;
    left_nxt       = left_r;
    right_nxt      = right_r;
    rs_nxt         = rs_r;
    re_nxt         = re_r;
    cur_bin_nxt    = cur_bin_r;
    last_bin_nxt   = last_bin_r;
    single_nxt     = single_r;
    first_nxt      = first_r;
    res_status_nxt = res_status_r;
    res_sum_nxt    = res_sum_r;
    clr_addr_nxt   = clr_addr_r;
    out_valid_nxt  = out_valid_r;
    out_rsp_nxt    = out_rsp_r;
    cb_we_c        = 1'b0;
    cb_wdata_c     = '0;
    mem_rd_en_c    = 1'b0;
    mem_wr_en_c    = 1'b0;
    mem_addr_c     = base_r + AW'(cur_bin_r);
    mem_wdata_c    = mem_rd_data + bca_pkg::SUM_W'(amt_c);
    div_req_c      = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      bca_pkg::S_CLEAR: begin
        mem_wr_en_c = 1'b1;
        mem_addr_c  = clr_addr_r;
        mem_wdata_c = '0;
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = bca_pkg::S_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end

      bca_pkg::S_IDLE: begin
        if (acc_c) begin
          req_nxt      = in_req;
          in_range_nxt = {1'b0, in_req.contig} < (bca_pkg::CONTIG_W + 1)'(NUM_CONTIGS);
          base_nxt     = AW'(in_req.contig[CIW-1:0]) * AW'(BINS_PER_CONTIG);
          state_nxt    = bca_pkg::S_LOOKUP;
        end
      end

      bca_pkg::S_LOOKUP: begin
        res_status_nxt = bca_pkg::ST_DROP;
        res_sum_nxt    = '0;
        state_nxt      = bca_pkg::S_FINISH;
        if (in_range_r) begin
          case (req_r.command)
            bca_pkg::CMD_ADD: begin
              if (bin_step_r != '0) begin
                div_req_c.start    = 1'b1;
                div_req_c.dividend = {1'b0, req_r.start_pos};
                div_req_c.divisor  = bin_step_r;
                state_nxt          = bca_pkg::S_DIV_LEFT;
              end
            end
            bca_pkg::CMD_LOAD: begin
              if (bin_step_r == '0) begin
                // A zero step saturates the bin count.
                cb_we_c        = 1'b1;
                cb_wdata_c     = BCW'(BINS_PER_CONTIG);
                res_status_nxt = bca_pkg::ST_CLAMP;
              end else begin
                div_req_c.start    = 1'b1;
                div_req_c.dividend = {1'b0, req_r.contig_length};
                div_req_c.divisor  = bin_step_r;
                state_nxt          = bca_pkg::S_DIV_LOAD;
              end
            end
            bca_pkg::CMD_READ: begin
              if (bca_pkg::DIV_W'(req_r.bin_index) < bca_pkg::DIV_W'(cb_bins_r)) begin
                mem_rd_en_c = 1'b1;
                mem_addr_c  = base_r + AW'(req_r.bin_index);
                state_nxt   = bca_pkg::S_READ_DATA;
              end
            end
            default: begin
              state_nxt = bca_pkg::S_FINISH;
            end
          endcase
        end
      end

      bca_pkg::S_DIV_LEFT: begin
        if (div_rsp.done) begin
          left_nxt           = div_rsp.quotient;
          rs_nxt             = div_rsp.remainder;
          div_req_c.start    = 1'b1;
          div_req_c.dividend = end_pos_c;
          div_req_c.divisor  = bin_step_r;
          state_nxt          = bca_pkg::S_DIV_RIGHT;
        end
      end

      bca_pkg::S_DIV_RIGHT: begin
        if (div_rsp.done) begin
          right_nxt = div_rsp.quotient;
          re_nxt    = div_rsp.remainder;
          state_nxt = bca_pkg::S_CHECK;
        end
      end

      bca_pkg::S_CHECK: begin
        if (right_r >= bca_pkg::DIV_W'(cb_bins_r)) begin
          state_nxt = bca_pkg::S_FINISH;
        end else begin
          // Both edge bins are now known to lie inside the contig's row.
          cur_bin_nxt  = BIW'(left_r);
          last_bin_nxt = BIW'(right_r);
          single_nxt   = (left_r == right_r);
          first_nxt    = 1'b1;
          state_nxt    = bca_pkg::S_BUMP_RD;
        end
      end

      bca_pkg::S_BUMP_RD: begin
        mem_rd_en_c = 1'b1;
        state_nxt   = bca_pkg::S_BUMP_WR;
      end

      bca_pkg::S_BUMP_WR: begin
        mem_wr_en_c = 1'b1;
        first_nxt   = 1'b0;
        if (cur_bin_r == last_bin_r) begin
          res_status_nxt = bca_pkg::ST_DONE;
          state_nxt      = bca_pkg::S_FINISH;
        end else begin
          cur_bin_nxt = cur_bin_r + 1'b1;
          state_nxt   = bca_pkg::S_BUMP_RD;
        end
      end

      bca_pkg::S_DIV_LOAD: begin
        if (div_rsp.done) begin
          cb_we_c = 1'b1;
          if (div_rsp.quotient >= bca_pkg::DIV_W'(BINS_PER_CONTIG)) begin
            cb_wdata_c     = BCW'(BINS_PER_CONTIG);
            res_status_nxt = bca_pkg::ST_CLAMP;
          end else begin
            cb_wdata_c     = BCW'(div_rsp.quotient) + 1'b1;
            res_status_nxt = bca_pkg::ST_DONE;
          end
          state_nxt = bca_pkg::S_FINISH;
        end
      end

      bca_pkg::S_READ_DATA: begin
        res_sum_nxt    = mem_rd_data;
        res_status_nxt = bca_pkg::ST_READ;
        state_nxt      = bca_pkg::S_FINISH;
      end

      bca_pkg::S_FINISH: begin
        // The result waits here only while the previous one is still held.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt         = 1'b1;
          out_rsp_nxt.status    = res_status_r;
          out_rsp_nxt.depth_sum = res_sum_r;
          state_nxt             = bca_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = bca_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bca_pkg::S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      bin_step_r  <= bca_pkg::STEP_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        bin_step_r <= cfg_wr_data;
      end
    end
    req_r        <= req_nxt;
    in_range_r   <= in_range_nxt;
    base_r       <= base_nxt;
    left_r       <= left_nxt;
    right_r      <= right_nxt;
    rs_r         <= rs_nxt;
    re_r         <= re_nxt;
    cur_bin_r    <= cur_bin_nxt;
    last_bin_r   <= last_bin_nxt;
    single_r     <= single_nxt;
    first_r      <= first_nxt;
    res_status_r <= res_status_nxt;
    res_sum_r    <= res_sum_nxt;
    out_rsp_r    <= out_rsp_nxt;
  end

  // Contig table: read when a request is taken, written by load commands.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cb_vld_r <= '0;
    end else if (cb_we_c) begin
      cb_vld_r[cb_widx_c] <= 1'b1;
    end
    if (cb_we_c) begin
      cb_mem[cb_widx_c] <= cb_wdata_c;
    end
    if (acc_c) begin
      cb_bins_r <= cb_vld_r[cb_ridx_c] ? cb_mem[cb_ridx_c] : '0;
    end
  end

  bca_divider u_divider (
    .clk     (clk),
    .rst_n   (rst_n),
    .div_req (div_req_c),
    .div_rsp (div_rsp)
  );

  bca_depth_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_depth_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en_c),
    .rd_en   (mem_rd_en_c),
    .addr    (mem_addr_c),
    .wr_data (mem_wdata_c),
    .rd_data (mem_rd_data)
  );

endmodule
`default_nettype wire
